// ----- sv/hbs_pkg.sv -----
// hbs_pkg: shared types, constants and register map for the height-map sampler
// used by every module of heightmap_bilinear_sampler but hbs_ram; no dependencies
package hbs_pkg;

    // fixed field widths
    localparam int STORE_AW   = 16;
    localparam int STORE_DW   = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int POS_W      = 20;
    localparam int OUT_W      = 27;
    localparam int OUT_FRAC   = 8;

    // defaults for the top-level parameters
    localparam int DEF_GRID_SIDE = 256;
    localparam int DEF_FRAC_BITS = 8;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_WORLD_HALF    = 2'd0;
    localparam logic [1:0] REG_INV_GRID_STEP = 2'd1;
    localparam logic [1:0] REG_HEIGHT_BASE   = 2'd2;

    localparam logic [18:0] WORLD_HALF_RST    = 19'd131072;
    localparam logic [19:0] INV_GRID_STEP_RST = 20'd65536;
    localparam logic [17:0] HEIGHT_BASE_RST   = 18'd0;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [18:0]        world_half;
        logic [19:0]        inv_grid_step;
        logic signed [17:0] height_base;
    } hbs_cfg_t;

    // per-stage load enables of the sampler pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
        logic s8;
    } hbs_ld_t;

endpackage

// ----- sv/hbs_ram.sv -----
// hbs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/hbs_regs.sv -----
// hbs_regs: apb-style configuration registers of the height-map sampler
// depends on hbs_pkg
module hbs_regs
    import hbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output hbs_cfg_t           cfg
);

    hbs_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.world_half    <= WORLD_HALF_RST;
            cfg_reg.inv_grid_step <= INV_GRID_STEP_RST;
            cfg_reg.height_base   <= HEIGHT_BASE_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_WORLD_HALF:    cfg_reg.world_half    <= pwdata[18:0];
                REG_INV_GRID_STEP: cfg_reg.inv_grid_step <= pwdata[19:0];
                REG_HEIGHT_BASE:   cfg_reg.height_base   <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_WORLD_HALF:    prdata = {13'd0, cfg_reg.world_half};
            REG_INV_GRID_STEP: prdata = {12'd0, cfg_reg.inv_grid_step};
            REG_HEIGHT_BASE:   prdata = {{14{cfg_reg.height_base[17]}}, cfg_reg.height_base};
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/hbs_coord.sv -----
// hbs_coord: world position to clamped grid coordinate, three register stages
// depends on hbs_pkg
module hbs_coord
    import hbs_pkg::*;
#(
    parameter int GRID_SIDE = DEF_GRID_SIDE,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int IW = $clog2(GRID_SIDE)
) (
    input  logic                 aclk,
    input  hbs_ld_t              ld,
    input  hbs_cfg_t             cfg,
    input  logic [POS_W-1:0]     pos,
    output logic [IW-1:0]        grid_idx,
    output logic [FRAC_BITS-1:0] frac
);

    localparam int CW    = IW + FRAC_BITS;
    localparam int PW    = 40;
    localparam int SHIFT = 24 - FRAC_BITS;
    localparam logic [PW-1:0] TOP = PW'(((GRID_SIDE - 1) << FRAC_BITS) - 1);

    logic signed [POS_W:0] sum_next;
    logic signed [POS_W:0] sum_reg;
    logic [POS_W-1:0]      mag;
    logic [PW-1:0]         prod_reg;
    logic [PW-1:0]         scaled;
    logic [CW-1:0]         coord;
    logic [IW-1:0]         grid_idx_reg;
    logic [FRAC_BITS-1:0]  frac_reg;

    // sign-extended position plus the half world extent
    assign sum_next = $signed({pos[POS_W-1], pos}) + $signed({2'b00, cfg.world_half});

    // nonpositive sums map to coordinate zero
    assign mag = (!sum_reg[POS_W] && (sum_reg != '0)) ? sum_reg[POS_W-1:0] : '0;

    assign scaled = prod_reg >> SHIFT;
    assign coord  = (scaled > TOP) ? TOP[CW-1:0] : scaled[CW-1:0];

    always_ff @(posedge aclk) begin
        if (ld.s1) begin
            sum_reg <= sum_next;
        end
        if (ld.s2) begin
            prod_reg <= PW'(mag) * PW'(cfg.inv_grid_step);
        end
        if (ld.s3) begin
            grid_idx_reg <= coord[CW-1:FRAC_BITS];
            frac_reg     <= coord[FRAC_BITS-1:0];
        end
    end

    assign grid_idx = grid_idx_reg;
    assign frac     = frac_reg;

endmodule

// ----- sv/hbs_blend.sv -----
// hbs_blend: bilinear blend of four samples plus base height, three register stages
// depends on hbs_pkg
module hbs_blend
    import hbs_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    aclk,
    input  hbs_ld_t                 ld,
    input  hbs_cfg_t                cfg,
    input  logic [STORE_DW-1:0]     h00,
    input  logic [STORE_DW-1:0]     h01,
    input  logic [STORE_DW-1:0]     h10,
    input  logic [STORE_DW-1:0]     h11,
    input  logic [FRAC_BITS-1:0]    tx,
    input  logic [FRAC_BITS-1:0]    tz,
    output logic signed [OUT_W-1:0] height_out
);

    localparam int RW   = STORE_DW + FRAC_BITS;
    localparam int VW   = STORE_DW + 2 * FRAC_BITS;
    localparam int DROP = 2 * FRAC_BITS - OUT_FRAC;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0]   wx0;
    logic [FRAC_BITS:0]   wz0;
    logic [RW:0]          row_a;
    logic [RW:0]          row_b;
    logic [RW-1:0]        a_reg;
    logic [RW-1:0]        b_reg;
    logic [FRAC_BITS-1:0] tz_reg;
    logic [VW:0]          v_sum;
    logic [VW-1:0]        v_reg;
    logic [OUT_W-1:0]     out_next;
    logic [OUT_W-1:0]     out_reg;

    assign wx0 = ONE - {1'b0, tx};
    assign wz0 = ONE - {1'b0, tz_reg};

    // weights sum to one, so each blend fits without the carry bit
    assign row_a = (RW+1)'(h00) * (RW+1)'(wx0) + (RW+1)'(h01) * (RW+1)'(tx);
    assign row_b = (RW+1)'(h10) * (RW+1)'(wx0) + (RW+1)'(h11) * (RW+1)'(tx);
    assign v_sum = (VW+1)'(a_reg) * (VW+1)'(wz0) + (VW+1)'(b_reg) * (VW+1)'(tz_reg);

    assign out_next = OUT_W'(v_reg[VW-1:DROP])
                    + {cfg.height_base[17], cfg.height_base, {OUT_FRAC{1'b0}}};

    always_ff @(posedge aclk) begin
        if (ld.s6) begin
            a_reg  <= row_a[RW-1:0];
            b_reg  <= row_b[RW-1:0];
            tz_reg <= tz;
        end
        if (ld.s7) begin
            v_reg <= v_sum[VW-1:0];
        end
        if (ld.s8) begin
            out_reg <= out_next;
        end
    end

    assign height_out = $signed(out_reg);

endmodule

// ----- sv/heightmap_bilinear_sampler.sv -----
// heightmap_bilinear_sampler: top level, pipeline control and replicated height store
// depends on hbs_pkg, hbs_ram, hbs_regs, hbs_coord, hbs_blend

// The sampler keeps a GRID_SIDE x GRID_SIDE grid of 16-bit heights (cm) in a
// 65536-entry store and takes one transaction per clock on s_ while s_ready is
// high: a write (s_cmd = 0) stores s_sample_value at s_sample_index and gives
// no result, a query (s_cmd = 1) maps (s_pos_x, s_pos_z) in signed Q12.8
// metres onto the grid and returns the bilinear blend of the four neighbouring
// samples plus height_base, as cm with 8 fraction bits, on m_height_out. Every
// transaction enters one eight-stage pipeline, and a write retires at the store.
// The four copies of the height store sustain one transaction per cycle while
// m_ready does not stall the output: each copy has one read port, so the four
// neighbours are read in the same cycle, and every write goes to all copies.
// Reads and writes reach the store in the stage-4 slot in transaction order, so
// a query sees every write accepted before it with no forwarding. Stages advance
// independently, so bubbles close up while a result waits on m_ready. A sample
// must be written before a query reads it; the store has no reset and needs no
// clearing pass. Registers (apb, byte address 4*i): world_half at 0x0,
// inv_grid_step at 0x4, height_base at 0x8, and they are only to be written
// while no query is in flight.
module heightmap_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int GRID_SIDE = DEF_GRID_SIDE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [STORE_AW-1:0]      s_sample_index,
    input  logic [STORE_DW-1:0]      s_sample_value,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_z,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_height_out
);

    localparam int IW = $clog2(GRID_SIDE);
    localparam logic [31:0] SIDE_W = 32'(GRID_SIDE);
    localparam logic [IW-1:0] MAX_CELL = IW'(GRID_SIDE - 2);

    hbs_cfg_t cfg;
    hbs_ld_t  ld;

    // stage valids; from stage 5 on only queries occupy the pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic m_valid_reg;

    // command and write payload travel with the transaction up to the store
    logic                cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;
    logic [STORE_AW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [STORE_DW-1:0] val1_reg, val2_reg, val3_reg, val4_reg;

    logic [IW-1:0]        ix3, iz3;
    logic [FRAC_BITS-1:0] tx3, tz3;
    logic [FRAC_BITS-1:0] tx4_reg, tz4_reg, tx5_reg, tz5_reg;

    // neighbour addresses: (x,z), (x+1,z), (x,z+1), (x+1,z+1)
    logic [31:0]          lin;
    logic [31:0]          nb_off [4];
    logic [STORE_AW-1:0]  addr4_reg [4];
    logic [STORE_DW-1:0]  sample [4];

    logic store_we;

    // each stage loads when it is empty or its successor loads
    always_comb begin
        ld.s8 = !m_valid_reg || m_ready;
        ld.s7 = !v7_reg || ld.s8;
        ld.s6 = !v6_reg || ld.s7;
        ld.s5 = !v5_reg || ld.s6;
        ld.s4 = !v4_reg || ld.s5;
        ld.s3 = !v3_reg || ld.s4;
        ld.s2 = !v2_reg || ld.s3;
        ld.s1 = !v1_reg || ld.s2;
    end

    assign s_ready = ld.s1;
    assign m_valid = m_valid_reg;

    hbs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ld.s1) v1_reg <= s_valid;
            if (ld.s2) v2_reg <= v1_reg;
            if (ld.s3) v3_reg <= v2_reg;
            if (ld.s4) v4_reg <= v3_reg;
            // a write retires at the store, only queries go on
            if (ld.s5) v5_reg <= v4_reg && (cmd4_reg == CMD_QUERY);
            if (ld.s6) v6_reg <= v5_reg;
            if (ld.s7) v7_reg <= v6_reg;
            if (ld.s8) m_valid_reg <= v7_reg;
        end
    end

    // transaction payload
    always_ff @(posedge aclk) begin
        if (ld.s1) begin
            cmd1_reg <= s_cmd;
            idx1_reg <= s_sample_index;
            val1_reg <= s_sample_value;
        end
        if (ld.s2) begin
            cmd2_reg <= cmd1_reg;
            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;
        end
        if (ld.s3) begin
            cmd3_reg <= cmd2_reg;
            idx3_reg <= idx2_reg;
            val3_reg <= val2_reg;
        end
        if (ld.s4) begin
            cmd4_reg <= cmd3_reg;
            idx4_reg <= idx3_reg;
            val4_reg <= val3_reg;
            tx4_reg  <= tx3;
            tz4_reg  <= tz3;
            for (int k = 0; k < 4; k++) begin
                addr4_reg[k] <= lin[STORE_AW-1:0] + nb_off[k][STORE_AW-1:0];
            end
        end
        if (ld.s5) begin
            tx5_reg <= tx4_reg;
            tz5_reg <= tz4_reg;
        end
    end

    // grid coordinates, stages 1 to 3
    hbs_coord #(
        .GRID_SIDE (GRID_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_coord_x (
        .aclk     (aclk),
        .ld       (ld),
        .cfg      (cfg),
        .pos      (s_pos_x),
        .grid_idx (ix3),
        .frac     (tx3)
    );

    hbs_coord #(
        .GRID_SIDE (GRID_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_coord_z (
        .aclk     (aclk),
        .ld       (ld),
        .cfg      (cfg),
        .pos      (s_pos_z),
        .grid_idx (iz3),
        .frac     (tz3)
    );

    // linear index of the lower-left neighbour, wraps modulo the store depth
    assign lin = 32'(iz3) * SIDE_W + 32'(ix3);
    assign nb_off[0] = 32'd0;
    assign nb_off[1] = 32'd1;
    assign nb_off[2] = SIDE_W;
    assign nb_off[3] = SIDE_W + 32'd1;

    // store access slot: a write or four reads as stage 4 hands over to stage 5
    assign store_we = ld.s5 && v4_reg && (cmd4_reg == CMD_WRITE);

    for (genvar k = 0; k < 4; k++) begin : g_store
        hbs_ram #(
            .WIDTH (STORE_DW),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (store_we),
            .waddr (idx4_reg),
            .wdata (val4_reg),
            .re    (ld.s5),
            .raddr (addr4_reg[k]),
            .rdata (sample[k])
        );
    end

    // blend, stages 6 to 8; the output register sits in the blend unit
    hbs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk       (aclk),
        .ld         (ld),
        .cfg        (cfg),
        .h00        (sample[0]),
        .h01        (sample[1]),
        .h10        (sample[2]),
        .h11        (sample[3]),
        .tx         (tx5_reg),
        .tz         (tz5_reg),
        .height_out (m_height_out)
    );

`ifndef SYNTH
    // an empty first stage always takes a transaction
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_ready)
        else $error("s_ready low with stage 1 empty");

    // a query that leaves the store slot lands in stage 5
    a_query_reaches_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld.s5 && v4_reg && (cmd4_reg == CMD_QUERY)) |=> v5_reg)
        else $error("query lost at the store read");

    // a result only appears behind a query in stage 7
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v7_reg))
        else $error("result without a query");

    // clamped cells keep all four neighbours inside the grid
    a_cell_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && (cmd3_reg == CMD_QUERY)) |-> (ix3 <= MAX_CELL && iz3 <= MAX_CELL))
        else $error("grid cell outside the clamp range");
`endif

endmodule

// ----- bench/heightmap_bilinear_sampler_tb.sv -----
// heightmap_bilinear_sampler_tb: self-checking bench for the bilinear height-map sampler
// depends on hbs_pkg and heightmap_bilinear_sampler; predicts query results the table leaves open
// directed table first, then randomized phases under several register settings
module heightmap_bilinear_sampler_tb
    import hbs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID           = DEF_GRID_SIDE;
    localparam int FRAC           = DEF_FRAC_BITS;
    localparam int PIPE_LATENCY   = 8;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 150;
    localparam int LONG_PHASE     = 3;
    localparam int POS_MAX        = (1 << (POS_W - 1)) - 1;
    localparam int POS_MIN        = -(1 << (POS_W - 1));
    localparam int STEP_MAX       = (1 << 20) - 1;
    localparam int HALF_MAX       = (1 << 19) - 1;

    // one row of the directed table
    typedef enum logic [1:0] {ROW_CONFIG, ROW_WRITE, ROW_QUERY} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        logic [1:0] reg_sel;
        int         idx;
        int         val;
        int         x;
        int         z;
        bit         known;
        int         want;
    } stim_row_t;

    // config rows carry the register value in val; reg_sel is filler elsewhere
    localparam int DIRECTED_ROWS = 28;
    localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
        // flat patch at the grid origin, queried from the most negative corner
        '{ROW_WRITE,  REG_WORLD_HALF,    0,      1000,    0,       0,       1'b0, 0},
        '{ROW_WRITE,  REG_WORLD_HALF,    1,      1000,    0,       0,       1'b0, 0},
        '{ROW_WRITE,  REG_WORLD_HALF,    256,    1000,    0,       0,       1'b0, 0},
        '{ROW_WRITE,  REG_WORLD_HALF,    257,    1000,    0,       0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       POS_MIN, POS_MIN, 1'b1, 256000},
        // full-scale patch at the far corner, reached through the clamp
        '{ROW_WRITE,  REG_WORLD_HALF,    65278,  65535,   0,       0,       1'b0, 0},
        '{ROW_WRITE,  REG_WORLD_HALF,    65279,  65535,   0,       0,       1'b0, 0},
        '{ROW_WRITE,  REG_WORLD_HALF,    65534,  65535,   0,       0,       1'b0, 0},
        '{ROW_WRITE,  REG_WORLD_HALF,    65535,  65535,   0,       0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       POS_MAX, POS_MAX, 1'b1, 16776960},
        '{ROW_WRITE,  REG_WORLD_HALF,    32896,  0,       0,       0,       1'b0, 0},
        // interior point with both fractions nonzero
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       -130772, -130995, 1'b0, 0},
        // base extremes
        '{ROW_CONFIG, REG_HEIGHT_BASE,   0,      -100000, 0,       0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       POS_MIN, POS_MIN, 1'b1, -25344000},
        '{ROW_CONFIG, REG_HEIGHT_BASE,   0,      100000,  0,       0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       POS_MAX, POS_MAX, 1'b1, 42376960},
        // zero reciprocal step pins every position to the origin
        '{ROW_CONFIG, REG_INV_GRID_STEP, 0,      0,       0,       0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       -1,      1,       1'b1, 25856000},
        // largest half extent and step
        '{ROW_CONFIG, REG_WORLD_HALF,    0,      HALF_MAX, 0,      0,       1'b0, 0},
        '{ROW_CONFIG, REG_INV_GRID_STEP, 0,      STEP_MAX, 0,      0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       POS_MIN, -524287, 1'b1, 25856000},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       POS_MAX, 0,       1'b1, 42376960},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       -524286, -524280, 1'b0, 0},
        // smallest half extent and step
        '{ROW_CONFIG, REG_WORLD_HALF,    0,      0,       0,       0,       1'b0, 0},
        '{ROW_CONFIG, REG_INV_GRID_STEP, 0,      1,       0,       0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       POS_MAX, POS_MAX, 1'b0, 0},
        // raw 18-bit base minimum
        '{ROW_CONFIG, REG_HEIGHT_BASE,   0,      -131072, 0,       0,       1'b0, 0},
        '{ROW_QUERY,  REG_WORLD_HALF,    0,      0,       300,     12345,   1'b0, 0}
    };

    // clock, reset and dut ports; every input starts at a known value
    logic                    aclk;
    logic                    aresetn        = 1'b0;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [PADDR_W-1:0]      paddr          = '0;
    logic [PDATA_W-1:0]      pwdata         = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic                    s_cmd          = CMD_WRITE;
    logic [STORE_AW-1:0]     s_sample_index = '0;
    logic [STORE_DW-1:0]     s_sample_value = '0;
    logic signed [POS_W-1:0] s_pos_x        = '0;
    logic signed [POS_W-1:0] s_pos_z        = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [OUT_W-1:0] m_height_out;

    // shadow of the register file and of the height store
    hbs_cfg_t            cfg_shadow = '{WORLD_HALF_RST, INV_GRID_STEP_RST, HEIGHT_BASE_RST};
    logic [STORE_DW-1:0] height_mem  [STORE_DEPTH];
    bit                  written_map [STORE_DEPTH];

    // heights still owed by the dut, oldest first
    logic signed [OUT_W-1:0] expected_heights[$];

    bit throttle     = 1'b1;
    int items_sent   = 0;
    int height_errors = 0;
    int stall_cycles = 0;

    heightmap_bilinear_sampler #(
        .GRID_SIDE (GRID),
        .FRAC_BITS (FRAC)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_sample_index (s_sample_index),
        .s_sample_value (s_sample_value),
        .s_pos_x        (s_pos_x),
        .s_pos_z        (s_pos_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_height_out   (m_height_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // world position to grid coordinate with FRAC fraction bits, clamped
    function automatic int grid_coord(input logic signed [POS_W-1:0] pos);
        longint shifted;
        longint scaled;
        longint top;
        top = (longint'(GRID - 1) << FRAC) - 1;
        shifted = longint'(pos) + longint'(cfg_shadow.world_half);
        if (shifted <= 0)
            return 0;
        scaled = (shifted * longint'(cfg_shadow.inv_grid_step)) >> (24 - FRAC);
        return int'((scaled > top) ? top : scaled);
    endfunction

    // bilinear blend of the four neighbours plus base, cm with 8 fraction bits
    function automatic logic signed [OUT_W-1:0] predict_height(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] z
    );
        longint one;
        longint fx, fz, tx, tz, base_idx;
        longint h00, h01, h10, h11, a, b, v, r;
        one      = longint'(1) << FRAC;
        fx       = grid_coord(x);
        fz       = grid_coord(z);
        tx       = fx & (one - 1);
        tz       = fz & (one - 1);
        base_idx = (fz >> FRAC) * GRID + (fx >> FRAC);
        h00      = height_mem[STORE_AW'(base_idx)];
        h01      = height_mem[STORE_AW'(base_idx + 1)];
        h10      = height_mem[STORE_AW'(base_idx + GRID)];
        h11      = height_mem[STORE_AW'(base_idx + GRID + 1)];
        a        = h00 * (one - tx) + h01 * tx;
        b        = h10 * (one - tx) + h11 * tx;
        v        = a * (one - tz) + b * tz;
        r        = (v >> (2 * FRAC - OUT_FRAC)) + longint'(cfg_shadow.height_base) * 256;
        return OUT_W'(r);
    endfunction

    function automatic logic signed [POS_W-1:0] clip_pos(input longint p);
        if (p > POS_MAX)
            return POS_W'(POS_MAX);
        if (p < POS_MIN)
            return POS_W'(POS_MIN);
        return POS_W'(p);
    endfunction

    // drive one transaction, hold it until accepted, then update the shadow state
    task automatic send_item(
        input logic                    cmd,
        input logic [STORE_AW-1:0]     idx,
        input logic [STORE_DW-1:0]     val,
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] z,
        input bit                      known,
        input int                      want
    );
        int gap;
        gap = 0;
        if (throttle)
            while ($urandom_range(99) < 36) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_sample_index <= idx;
        s_sample_value <= val;
        s_pos_x        <= x;
        s_pos_z        <= z;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge
        if (cmd == CMD_WRITE) begin
            height_mem[idx]  = val;
            written_map[idx] = 1'b1;
        end else begin
            expected_heights.insert(expected_heights.size(),
                                    known ? OUT_W'(want) : predict_height(x, z));
        end
        items_sent++;
    endtask

    // make sure the four samples a query will read hold written data
    task automatic prime_cell(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] z,
        input bit                      rewrite
    );
        int                  base_idx;
        int                  n;
        logic [STORE_AW-1:0] idx;
        base_idx = (grid_coord(z) >> FRAC) * GRID + (grid_coord(x) >> FRAC);
        for (n = 0; n < 4; n++) begin
            idx = STORE_AW'(base_idx + (n >> 1) * GRID + (n & 1));
            if (rewrite || !written_map[idx])
                send_item(CMD_WRITE, idx, STORE_DW'($urandom), POS_W'($urandom),
                          POS_W'($urandom), 1'b0, 0);
        end
    endtask

    // stop sending, let every owed result drain, then let the pipeline empty
    task automatic quiesce();
        s_valid <= 1'b0;
        while (expected_heights.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    // apb write: setup, then access until pready, then idle with psel low
    task automatic write_register(input logic [1:0] sel, input int value);
        logic [PDATA_W-1:0] data;
        data = '0;
        case (sel)
            REG_WORLD_HALF: begin
                data = PDATA_W'(value[18:0]);
                cfg_shadow.world_half = value[18:0];
            end
            REG_INV_GRID_STEP: begin
                data = PDATA_W'(value[19:0]);
                cfg_shadow.inv_grid_step = value[19:0];
            end
            REG_HEIGHT_BASE: begin
                data = PDATA_W'(value[17:0]);
                cfg_shadow.height_base = value[17:0];
            end
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({sel, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: random backpressure and in-order comparison
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_heights.size() == 0) begin
                if (height_errors < 10)
                    $display("unexpected height transaction: got %0d", m_height_out);
                height_errors++;
            end else begin
                if (m_height_out !== expected_heights[0]) begin
                    if (height_errors < 10)
                        $display("height_out mismatch: expected %0d got %0d",
                                 expected_heights[0], m_height_out);
                    height_errors++;
                end
                void'(expected_heights.pop_front());
            end
        end
        m_ready <= throttle ? ($urandom_range(99) >= 36) : 1'b1;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial begin
        int                      n;
        int                      phase;
        int                      half;
        int                      step;
        int                      base;
        int                      target;
        longint                  span;
        logic signed [POS_W-1:0] qx;
        logic signed [POS_W-1:0] qz;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (n = 0; n < DIRECTED_ROWS; n++) begin
            case (DIRECTED[n].kind)
                ROW_CONFIG: begin
                    quiesce();
                    write_register(DIRECTED[n].reg_sel, DIRECTED[n].val);
                end
                ROW_WRITE: begin
                    send_item(CMD_WRITE, STORE_AW'(DIRECTED[n].idx), STORE_DW'(DIRECTED[n].val),
                              POS_W'($urandom), POS_W'($urandom), 1'b0, 0);
                end
                ROW_QUERY: begin
                    qx = POS_W'(DIRECTED[n].x);
                    qz = POS_W'(DIRECTED[n].z);
                    prime_cell(qx, qz, 1'b0);
                    send_item(CMD_QUERY, STORE_AW'($urandom), STORE_DW'($urandom), qx, qz,
                              DIRECTED[n].known, DIRECTED[n].want);
                end
                default: ;
            endcase
        end

        // random phases, each under fresh register settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // full drain before touching the registers
            quiesce();

            case ($urandom_range(9))
                0:       half = 0;
                1:       half = HALF_MAX;
                default: half = $urandom_range(2048, 262143);
            endcase
            // step chosen so the grid roughly covers the world, with spread
            span = ((longint'(255) << 24) / (2 * half + 1)) * $urandom_range(60, 140) / 100;
            step = int'((span > STEP_MAX) ? STEP_MAX : ((span < 1) ? 1 : span));
            case ($urandom_range(9))
                0:       step = STEP_MAX;
                1:       step = $urandom_range(1, 255);
                default: ;
            endcase
            case ($urandom_range(9))
                0:       base = -100000;
                1:       base = 100000;
                2:       base = -131072;
                3:       base = 131071;
                default: base = int'($urandom_range(200000)) - 100000;
            endcase
            write_register(REG_WORLD_HALF, half);
            write_register(REG_INV_GRID_STEP, step);
            write_register(REG_HEIGHT_BASE, base);

            // one phase runs with no idling on either side
            throttle = (phase != LONG_PHASE);

            // range of positions that lands inside the grid
            span = (longint'(255) << 24) / step;
            if (span > (longint'(1) << POS_W))
                span = longint'(1) << POS_W;

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                case ($urandom_range(99) / 12)
                    0: begin
                        // stray write anywhere in the store
                        send_item(CMD_WRITE, STORE_AW'($urandom), STORE_DW'($urandom),
                                  POS_W'($urandom), POS_W'($urandom), 1'b0, 0);
                    end
                    1: begin
                        // any position at all, mostly clamped
                        qx = POS_W'($urandom);
                        qz = POS_W'($urandom);
                        prime_cell(qx, qz, 1'b0);
                        send_item(CMD_QUERY, STORE_AW'($urandom), STORE_DW'($urandom),
                                  qx, qz, 1'b0, 0);
                    end
                    default: begin
                        // position inside the grid, sometimes right after fresh writes
                        qx = clip_pos(-longint'(half) + $urandom_range(0, int'(span)));
                        qz = clip_pos(-longint'(half) + $urandom_range(0, int'(span)));
                        prime_cell(qx, qz, $urandom_range(99) < 20);
                        send_item(CMD_QUERY, STORE_AW'($urandom), STORE_DW'($urandom),
                                  qx, qz, 1'b0, 0);
                    end
                endcase
            end
        end

        // wait out the tail of the pipeline
        s_valid <= 1'b0;
        while (expected_heights.size() != 0) @(posedge aclk);
        repeat (2 * PIPE_LATENCY) @(posedge aclk);

        if (height_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/hbs_pkg.sv
sv/hbs_ram.sv
sv/hbs_regs.sv
sv/hbs_coord.sv
sv/hbs_blend.sv
sv/heightmap_bilinear_sampler.sv
bench/heightmap_bilinear_sampler_tb.sv
